// ----- hw/rtl/akf_pkg.sv -----
// Shared constants and saturation helpers for the angle Kalman filter.
package akf_pkg;

  localparam int TIME_FRAC     = 16;
  localparam int NOISE_FRAC    = 30;
  localparam int COV_FRAC_BITS = 32;
  localparam logic [63:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

  // register indexes of the config port
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -48'sh8000_0000_0000;
    return 48'(v);
  endfunction

  // unsigned Q2.30 noise term to covariance format, rounded
  function automatic logic signed [63:0] noise_to_cov(input logic [31:0] q);
    logic [127:0] w;
    w = (128'(q) << COV_FRAC_BITS) + (128'(1) << (NOISE_FRAC - 1));
    return 64'(w >> NOISE_FRAC);
  endfunction

endpackage

// ----- hw/rtl/akf_mul.sv -----
// Multi-cycle signed multiplier with rounded right shift and saturation.
module akf_mul import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               cov_shift,
  output logic               done,
  output logic signed [63:0] result
);

  logic [63:0]  ua, ub;
  logic         neg, shsel, busy;
  logic [127:0] acc;
  logic [2:0]   cnt;

  // one 32x32 partial product per cycle
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_w;
  always_comb begin
    ah = cnt[1] ? ua[63:32] : ua[31:0];
    bh = cnt[0] ? ub[63:32] : ub[31:0];
    pp = 64'(ah) * 64'(bh);
    if (cnt[1] && cnt[0]) pp_w = 128'(pp) << 64;
    else if (cnt[1] || cnt[0]) pp_w = 128'(pp) << 32;
    else pp_w = 128'(pp);
  end

  // round half away from zero on the magnitude, then clamp
  logic [127:0] rnd, shr;
  logic [63:0]  m;
  always_comb begin
    if (shsel) begin
      rnd = acc + (128'(1) << (COV_FRAC_BITS - 1));
      shr = rnd >> COV_FRAC_BITS;
    end else begin
      rnd = acc + (128'(1) << (TIME_FRAC - 1));
      shr = rnd >> TIME_FRAC;
    end
    m = (shr > 128'(MAG_LIMIT)) ? MAG_LIMIT : shr[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ua    <= mag64(a);
        ub    <= mag64(b);
        neg   <= a[63] ^ b[63];
        shsel <= cov_shift;
        acc   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          acc <= acc + pp_w;
          cnt <= cnt + 3'd1;
        end else begin
          result <= neg ? -$signed(m) : $signed(m);
          done   <= 1'b1;
          busy   <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/akf_div.sv -----
// Bit-serial restoring divider: (n << COV_FRAC_BITS) / d, truncated, saturated.
module akf_div import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] n,
  input  logic signed [63:0] d,
  output logic               done,
  output logic signed [63:0] result
);

  localparam int NUM_W = 64 + COV_FRAC_BITS;
  localparam int CW    = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [63:0]      ud, rem, q;
  logic             ovf, neg, zero_d, busy;
  logic [CW-1:0]    cnt;

  // one quotient bit per cycle
  logic [64:0] rem_sh, rem_n;
  logic        ge;
  logic [63:0] qn, qf;
  always_comb begin
    rem_sh = {rem, num[NUM_W-1]};
    ge     = rem_sh >= {1'b0, ud};
    rem_n  = ge ? rem_sh - {1'b0, ud} : rem_sh;
    qn     = {q[62:0], ge};
    qf     = ovf ? MAG_LIMIT : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num    <= NUM_W'(mag64(n)) << COV_FRAC_BITS;
        ud     <= mag64(d);
        zero_d <= (d == 64'sd0);
        neg    <= n[63] ^ d[63];
        rem    <= '0;
        q      <= '0;
        ovf    <= 1'b0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (cnt != CW'(NUM_W)) begin
          rem <= rem_n[63:0];
          num <= num << 1;
          cnt <= cnt + CW'(1);
          if (!ovf) begin
            q <= qn;
            if (qn > MAG_LIMIT) ovf <= 1'b1;
          end
        end else begin
          if (zero_d) result <= '0;
          else result <= neg ? -$signed(qf) : $signed(qf);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/angle_kalman_filter.sv -----
// Top level of the two-state angle and gyro bias Kalman filter.
// Ten products run on one shared multiplier, each in the steps issue, four
// partial products, rounding and handoff. Two quotients run on a bit-serial
// divider of 64 + COV_FRAC_BITS steps, and the divider dominates. When the
// innovation covariance is zero the divisions are skipped. A set-angle item
// loads the measured angle and goes straight to the output. One item is in
// work at a time and in_stall is high meanwhile. The result sits in an output
// register, so the next item is accepted while it waits. Config writes are
// always ready and are meant for idle periods.
module angle_kalman_filter import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  input  logic [16:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] filtered_angle,
  output logic signed [31:0] unbiased_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    IDLE, RATE, M_ANG, M_D, M_P0, M_P3, D_K0, D_K1,
    M_KA, M_KB, M_P10, M_P11, M_P00, M_P01, OUT
  } state_t;

  state_t state;
  logic   issued;
  logic   load_out;

  logic [31:0]        qa, qb, rn;
  logic signed [31:0] angle, bias, last_rate, meas, mrate;
  logic [16:0]        dt;
  logic signed [47:0] p0, p1, p2, p3, k0, k1;
  logic signed [63:0] term, s, y;

  logic               mul_start, mul_done, mul_cov, div_start, div_done;
  logic signed [63:0] mul_a, mul_b, mul_res, div_n, div_res;

  assign in_stall  = (state != IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == OUT) && (!out_valid || !out_stall);

  // operand selection for the shared units
  always_comb begin
    mul_a     = 64'(k0);
    mul_b     = 64'(p0);
    mul_cov   = 1'b1;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_n     = 64'(p0);
    case (state)
      M_ANG: begin mul_a = 64'(dt); mul_b = 64'(last_rate); mul_cov = 1'b0; end
      M_D:   begin mul_a = 64'(dt); mul_b = 64'(p3); mul_cov = 1'b0; end
      M_P0:  begin mul_a = 64'(dt); mul_b = term; mul_cov = 1'b0; end
      M_P3:  begin mul_a = 64'(dt); mul_b = noise_to_cov(qb); mul_cov = 1'b0; end
      M_KA:  begin mul_a = 64'(k0); mul_b = y; end
      M_KB:  begin mul_a = 64'(k1); mul_b = y; end
      M_P10: begin mul_a = 64'(k1); mul_b = 64'(p0); end
      M_P11: begin mul_a = 64'(k1); mul_b = 64'(p1); end
      M_P00: begin mul_a = 64'(k0); mul_b = 64'(p0); end
      M_P01: begin mul_a = 64'(k0); mul_b = 64'(p1); end
      default: ;
    endcase
    case (state)
      M_ANG, M_D, M_P0, M_P3, M_KA, M_KB, M_P10, M_P11, M_P00, M_P01:
        mul_start = !issued;
      D_K0: div_start = !issued && (s != 64'sd0);
      D_K1: begin div_start = !issued; div_n = 64'(p2); end
      default: ;
    endcase
  end

  akf_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .cov_shift(mul_cov), .done(mul_done), .result(mul_res)
  );

  akf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(s),
    .done(div_done), .result(div_res)
  );

  logic signed [47:0] dv;
  assign dv = sat48(mul_res);

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      qa        <= 32'd1073742;
      qb        <= 32'd3221225;
      rn        <= 32'd32212255;
      angle     <= '0;
      bias      <= '0;
      last_rate <= '0;
      p0 <= '0; p1 <= '0; p2 <= '0; p3 <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ANGLE_NOISE: qa <= cfg_data;
          REG_BIAS_NOISE:  qb <= cfg_data;
          REG_MEAS_NOISE:  rn <= cfg_data;
          default: ;
        endcase
      end
      // result valid: set on load, cleared once taken
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (mul_start || div_start) issued <= 1'b1;

      case (state)
        IDLE: begin
          if (in_valid) begin
            meas  <= measured_angle;
            mrate <= measured_rate;
            dt    <= time_step;
            if (action) begin
              angle <= measured_angle;
              state <= OUT;
            end else begin
              state <= RATE;
            end
          end
        end
        RATE: begin
          last_rate <= sat32(64'(mrate) - 64'(bias));
          state     <= M_ANG;
        end
        M_ANG: if (mul_done) begin
          angle <= sat32(64'(angle) + mul_res); issued <= 1'b0; state <= M_D;
        end
        M_D: if (mul_done) begin
          term   <= 64'(dv) - 64'(p1) - 64'(p2) + noise_to_cov(qa);
          p1     <= sat48(64'(p1) - 64'(dv));
          p2     <= sat48(64'(p2) - 64'(dv));
          issued <= 1'b0;
          state  <= M_P0;
        end
        M_P0: if (mul_done) begin
          p0 <= sat48(64'(p0) + mul_res); issued <= 1'b0; state <= M_P3;
        end
        M_P3: if (mul_done) begin
          p3     <= sat48(64'(p3) + mul_res);
          y      <= 64'(meas) - 64'(angle);
          s      <= 64'(p0) + noise_to_cov(rn);
          issued <= 1'b0;
          state  <= D_K0;
        end
        D_K0: begin
          if (!issued && s == 64'sd0) begin
            // singular innovation: gains are zero
            k0 <= '0; k1 <= '0; state <= M_KA;
          end else if (div_done) begin
            k0 <= sat48(div_res); issued <= 1'b0; state <= D_K1;
          end
        end
        D_K1: if (div_done) begin
          k1 <= sat48(div_res); issued <= 1'b0; state <= M_KA;
        end
        M_KA: if (mul_done) begin
          angle <= sat32(64'(angle) + mul_res); issued <= 1'b0; state <= M_KB;
        end
        M_KB: if (mul_done) begin
          bias <= sat32(64'(bias) + mul_res); issued <= 1'b0; state <= M_P10;
        end
        // p0 and p1 are still the pre-shrink values for these two
        M_P10: if (mul_done) begin
          p2 <= sat48(64'(p2) - mul_res); issued <= 1'b0; state <= M_P11;
        end
        M_P11: if (mul_done) begin
          p3 <= sat48(64'(p3) - mul_res); issued <= 1'b0; state <= M_P00;
        end
        M_P00: if (mul_done) begin
          p0 <= sat48(64'(p0) - mul_res); issued <= 1'b0; state <= M_P01;
        end
        M_P01: if (mul_done) begin
          p1 <= sat48(64'(p1) - mul_res); issued <= 1'b0; state <= OUT;
        end
        OUT: begin
          if (load_out) begin
            filtered_angle <= angle;
            unbiased_rate  <= last_rate;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
